// File: rtl/wpf_pkg.sv
// shared constants, codes and controller/datapath types for the waypoint path follower
package wpf_pkg;

  // path storage and subdivision limits
  localparam int PATH_DEPTH     = 1024;
  localparam int MAX_SPLIT_LOG2 = 8;
  localparam int IDX_W          = $clog2(PATH_DEPTH);
  localparam int CNT_W          = IDX_W + 1;
  localparam int K_W            = $clog2(MAX_SPLIT_LOG2 + 1);
  localparam int J_W            = MAX_SPLIT_LOG2 + 1;
  localparam int FIT_W          = CNT_W + J_W;

  // field widths
  localparam int COORD_W    = 24;
  localparam int DIST_W     = 25;
  localparam int SQ_W       = 2 * DIST_W;
  localparam int TOL_W      = 24;
  localparam int ISH_W      = TOL_W + MAX_SPLIT_LOG2;
  localparam int REM_W      = 32;
  localparam int RETRY_W    = 8;
  localparam int CPC_W      = 10;
  localparam int RAW_W      = 11;
  localparam int PROD_W     = COORD_W + J_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [TOL_W-1:0]   TOL_RESET    = TOL_W'(256);
  localparam logic [TOL_W-1:0]   INTERP_RESET = TOL_W'(256);
  localparam logic [RETRY_W-1:0] RETRY_RESET  = RETRY_W'(40);

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL    = 2'd0,
    CFG_INTERP = 2'd1,
    CFG_TOTAL  = 2'd2,
    CFG_RETRY  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_RETRY      = 3'd1,
    ST_ADVANCED   = 3'd2,
    ST_COMPLETE   = 3'd3,
    ST_RETRY_STOP = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_FULL       = 3'd6
  } status_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_BEGIN,
    OP_RESET_ALL,
    OP_SKIP,
    OP_FIRST,
    OP_LOAD_DIST,
    OP_K_INC,
    OP_FULL,
    OP_SUB_INIT,
    OP_SUB_MUL,
    OP_SUB_ADD,
    OP_SUB_DIST,
    OP_SUB_WRITE,
    OP_EMPTY,
    OP_TGT_READ,
    OP_TGT_DIST,
    OP_CHECK,
    OP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LDIST,
    S_KSTEP,
    S_SMUL,
    S_SADD,
    S_SDIST_GO,
    S_SDIST,
    S_TRD,
    S_CDIST,
    S_DONE
  } fsm_state_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_SQX,
    DS_SQY,
    DS_ROOT
  } dist_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic raw_lt_cpc;
    logic count_zero;
    logic tp_ge_count;
    logic dist_done;
    logic k_more;
    logic fits;
    logic last_sub;
  } dp_stat_t;

endpackage

// File: rtl/wpf_if.sv
// input and result channel interfaces
interface wpf_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic signed [wpf_pkg::COORD_W-1:0] x_coord;
  logic signed [wpf_pkg::COORD_W-1:0] y_coord;
  logic                               is_checkpoint;

  modport source (output valid, cmd, x_coord, y_coord, is_checkpoint, input ready);
  modport sink   (input valid, cmd, x_coord, y_coord, is_checkpoint, output ready);
endinterface

interface wpf_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic                        checkpoint_passed;
  logic [wpf_pkg::CPC_W-1:0]   checkpoint_number;
  logic [wpf_pkg::IDX_W-1:0]   target_index;
  logic [wpf_pkg::DIST_W-1:0]  deviation;
  logic [wpf_pkg::REM_W-1:0]   remaining_distance;
  logic [wpf_pkg::CNT_W-1:0]   points_stored;

  modport source (output valid, status, checkpoint_passed, checkpoint_number, target_index,
                  deviation, remaining_distance, points_stored, input ready);
  modport sink   (input valid, status, checkpoint_passed, checkpoint_number, target_index,
                  deviation, remaining_distance, points_stored, output ready);
endinterface

// File: rtl/wpf_dist.sv
// euclidean distance unit: shared squarer then bitwise floor square root, one bit pair a cycle
module wpf_dist (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [wpf_pkg::COORD_W-1:0] ax,
  input  logic signed [wpf_pkg::COORD_W-1:0] ay,
  input  logic signed [wpf_pkg::COORD_W-1:0] bx,
  input  logic signed [wpf_pkg::COORD_W-1:0] by,
  output logic                               done,
  output logic [wpf_pkg::DIST_W-1:0]         span_len
);

  wpf_pkg::dist_state_t state_r, state_nxt;
  logic                        done_r, done_nxt;
  logic [wpf_pkg::DIST_W-1:0]  ux_r, uy_r;
  logic [wpf_pkg::SQ_W-1:0]    v_r, res_r, bit_r;
  logic [wpf_pkg::DIST_W-1:0]  dist_r;
  logic signed [wpf_pkg::COORD_W:0] dx, dy;
  logic [wpf_pkg::DIST_W-1:0]  sq_in;
  logic [wpf_pkg::SQ_W-1:0]    sq;
  logic [wpf_pkg::SQ_W-1:0]    trial;
  logic                        take;
  logic [wpf_pkg::SQ_W-1:0]    res_step;

  // signed differences; their magnitudes are registered in the idle state
  assign dx = {ax[wpf_pkg::COORD_W-1], ax} - {bx[wpf_pkg::COORD_W-1], bx};
  assign dy = {ay[wpf_pkg::COORD_W-1], ay} - {by[wpf_pkg::COORD_W-1], by};

  // one squarer shared by both axes
  assign sq_in = (state_r == wpf_pkg::DS_SQX) ? ux_r : uy_r;
  assign sq    = wpf_pkg::SQ_W'(sq_in) * wpf_pkg::SQ_W'(sq_in);

  // root step
  assign trial    = res_r + bit_r;
  assign take     = (v_r >= trial);
  assign res_step = take ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    case (state_r)
      wpf_pkg::DS_IDLE: if (start) state_nxt = wpf_pkg::DS_SQX;
      wpf_pkg::DS_SQX:  state_nxt = wpf_pkg::DS_SQY;
      wpf_pkg::DS_SQY:  state_nxt = wpf_pkg::DS_ROOT;
      wpf_pkg::DS_ROOT: begin
        if (bit_r[0]) begin
          state_nxt = wpf_pkg::DS_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = wpf_pkg::DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpf_pkg::DS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      wpf_pkg::DS_IDLE: begin
        ux_r <= dx[wpf_pkg::COORD_W] ? wpf_pkg::DIST_W'(-dx) : wpf_pkg::DIST_W'(dx);
        uy_r <= dy[wpf_pkg::COORD_W] ? wpf_pkg::DIST_W'(-dy) : wpf_pkg::DIST_W'(dy);
      end
      wpf_pkg::DS_SQX: v_r <= sq;
      wpf_pkg::DS_SQY: begin
        v_r   <= v_r + sq;
        res_r <= '0;
        bit_r <= wpf_pkg::SQ_W'(1) << (2 * (wpf_pkg::DIST_W - 1));
      end
      wpf_pkg::DS_ROOT: begin
        if (take) v_r <= v_r - trial;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) dist_r <= res_step[wpf_pkg::DIST_W-1:0];
      end
      default: ;
    endcase
  end

  assign done     = done_r;
  assign span_len = dist_r;

endmodule

// File: rtl/wpf_ctrl.sv
// controller: decodes each command, sequences loads and checks over the datapath, owns the channel handshakes
module wpf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wpf_pkg::dp_stat_t  stat,
  output wpf_pkg::dp_cmd_t   cmd
);

  wpf_pkg::fsm_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = wpf_pkg::OP_NONE;
    case (state_r)
      wpf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = wpf_pkg::OP_CAPTURE;
          state_nxt = wpf_pkg::S_DECODE;
        end
      end
      wpf_pkg::S_DECODE: begin
        state_nxt = wpf_pkg::S_DONE;
        case (stat.cmd)
          wpf_pkg::CMD_BEGIN: cmd.op = wpf_pkg::OP_BEGIN;
          wpf_pkg::CMD_RESET: cmd.op = wpf_pkg::OP_RESET_ALL;
          wpf_pkg::CMD_LOAD: begin
            if (stat.raw_lt_cpc) cmd.op = wpf_pkg::OP_SKIP;
            else if (stat.count_zero) cmd.op = wpf_pkg::OP_FIRST;
            else begin
              cmd.op    = wpf_pkg::OP_LOAD_DIST;
              state_nxt = wpf_pkg::S_LDIST;
            end
          end
          wpf_pkg::CMD_CHECK: begin
            if (stat.count_zero || stat.tp_ge_count) cmd.op = wpf_pkg::OP_EMPTY;
            else begin
              cmd.op    = wpf_pkg::OP_TGT_READ;
              state_nxt = wpf_pkg::S_TRD;
            end
          end
          default: ;
        endcase
      end
      wpf_pkg::S_LDIST: if (stat.dist_done) state_nxt = wpf_pkg::S_KSTEP;
      wpf_pkg::S_KSTEP: begin
        if (stat.k_more) cmd.op = wpf_pkg::OP_K_INC;
        else if (!stat.fits) begin
          cmd.op    = wpf_pkg::OP_FULL;
          state_nxt = wpf_pkg::S_DONE;
        end else begin
          cmd.op    = wpf_pkg::OP_SUB_INIT;
          state_nxt = wpf_pkg::S_SMUL;
        end
      end
      wpf_pkg::S_SMUL: begin
        cmd.op    = wpf_pkg::OP_SUB_MUL;
        state_nxt = wpf_pkg::S_SADD;
      end
      wpf_pkg::S_SADD: begin
        cmd.op    = wpf_pkg::OP_SUB_ADD;
        state_nxt = wpf_pkg::S_SDIST_GO;
      end
      wpf_pkg::S_SDIST_GO: begin
        cmd.op    = wpf_pkg::OP_SUB_DIST;
        state_nxt = wpf_pkg::S_SDIST;
      end
      wpf_pkg::S_SDIST: begin
        if (stat.dist_done) begin
          cmd.op    = wpf_pkg::OP_SUB_WRITE;
          state_nxt = stat.last_sub ? wpf_pkg::S_DONE : wpf_pkg::S_SMUL;
        end
      end
      wpf_pkg::S_TRD: begin
        cmd.op    = wpf_pkg::OP_TGT_DIST;
        state_nxt = wpf_pkg::S_CDIST;
      end
      wpf_pkg::S_CDIST: begin
        if (stat.dist_done) begin
          cmd.op    = wpf_pkg::OP_CHECK;
          state_nxt = wpf_pkg::S_DONE;
        end
      end
      wpf_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = wpf_pkg::OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = wpf_pkg::S_IDLE;
        end
      end
      default: state_nxt = wpf_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/wpf_dp.sv
// datapath: path memories, follower state, subdivision arithmetic and result register
module wpf_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wpf_pkg::dp_cmd_t                      cmd,
  output wpf_pkg::dp_stat_t                     stat,
  input  logic                                  cfg_we,
  input  logic [wpf_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [wpf_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [1:0]                            in_cmd,
  input  logic signed [wpf_pkg::COORD_W-1:0]    in_x,
  input  logic signed [wpf_pkg::COORD_W-1:0]    in_y,
  input  logic                                  in_cp,
  output wpf_pkg::status_t                      o_status,
  output logic                                  o_passed,
  output logic [wpf_pkg::CPC_W-1:0]             o_cpnum,
  output logic [wpf_pkg::IDX_W-1:0]             o_target,
  output logic [wpf_pkg::DIST_W-1:0]            o_dev,
  output logic [wpf_pkg::REM_W-1:0]             o_rem,
  output logic [wpf_pkg::CNT_W-1:0]             o_count
);

  localparam int PT_W = 2 * wpf_pkg::COORD_W + 1;

  // configuration
  logic [wpf_pkg::TOL_W-1:0]   tol_r, interp_r;
  logic [wpf_pkg::REM_W-1:0]   total_r;
  logic [wpf_pkg::RETRY_W-1:0] rlimit_r;

  // captured item
  wpf_pkg::cmd_t                     cmd_r;
  logic signed [wpf_pkg::COORD_W-1:0] x_r, y_r;
  logic                              cp_r;

  // follower state
  logic [wpf_pkg::CNT_W-1:0]   count_r;
  logic [wpf_pkg::RAW_W-1:0]   raw_r;
  logic [wpf_pkg::IDX_W-1:0]   tp_r;
  logic [wpf_pkg::CPC_W-1:0]   cpc_r;
  logic [wpf_pkg::RETRY_W-1:0] retry_r;
  logic [wpf_pkg::REM_W-1:0]   rem_r;

  // subdivision working registers
  logic signed [wpf_pkg::COORD_W-1:0] last_x_r, last_y_r, base_x_r, base_y_r, nx_r, ny_r;
  logic                               nmark_r;
  logic [wpf_pkg::K_W-1:0]            k_r;
  logic [wpf_pkg::J_W-1:0]            j_r;
  logic signed [wpf_pkg::PROD_W-1:0]  prodx_r, prody_r;

  // result of the current item
  wpf_pkg::status_t            status_r;
  logic                        passed_r;
  logic [wpf_pkg::CPC_W-1:0]   cpnum_r;
  logic [wpf_pkg::DIST_W-1:0]  dev_r;

  // memories
  logic [PT_W-1:0]             pt_mem [wpf_pkg::PATH_DEPTH];
  logic [wpf_pkg::DIST_W-1:0]  seg_mem [wpf_pkg::PATH_DEPTH];
  logic [PT_W-1:0]             pt_rd_r;
  logic [wpf_pkg::DIST_W-1:0]  seg_rd_r;

  logic                               wr_en;
  logic [wpf_pkg::IDX_W-1:0]          wr_addr;
  logic [PT_W-1:0]                    wr_pt;
  logic [wpf_pkg::DIST_W-1:0]         wr_seg;
  logic                               d_start, d_done;
  logic signed [wpf_pkg::COORD_W-1:0] d_ax, d_ay, d_bx, d_by;
  logic [wpf_pkg::DIST_W-1:0]         d_res;
  logic [wpf_pkg::J_W-1:0]            n_sub;
  logic signed [wpf_pkg::COORD_W:0]   diff_x, diff_y;
  logic signed [wpf_pkg::J_W:0]       j_s;
  logic signed [wpf_pkg::PROD_W-1:0]  shx, shy;
  logic signed [wpf_pkg::COORD_W-1:0] tgt_x, tgt_y;
  logic                               tgt_mark;
  logic                               reached, last_tgt;
  logic [wpf_pkg::RETRY_W-1:0]        retry_inc;

  // distance unit
  wpf_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (d_start),
    .ax       (d_ax),
    .ay       (d_ay),
    .bx       (d_bx),
    .by       (d_by),
    .done     (d_done),
    .span_len (d_res)
  );

  assign tgt_x    = pt_rd_r[PT_W-1 -: wpf_pkg::COORD_W];
  assign tgt_y    = pt_rd_r[wpf_pkg::COORD_W:1];
  assign tgt_mark = pt_rd_r[0];

  // distance operand selection
  always_comb begin
    d_start = 1'b0;
    d_ax    = x_r;
    d_ay    = y_r;
    d_bx    = last_x_r;
    d_by    = last_y_r;
    case (cmd.op)
      wpf_pkg::OP_LOAD_DIST: d_start = 1'b1;
      wpf_pkg::OP_SUB_DIST: begin
        d_start = 1'b1;
        d_ax    = nx_r;
        d_ay    = ny_r;
      end
      wpf_pkg::OP_TGT_DIST: begin
        d_start = 1'b1;
        d_bx    = tgt_x;
        d_by    = tgt_y;
      end
      default: ;
    endcase
  end

  // subdivision arithmetic
  assign n_sub  = wpf_pkg::J_W'(1) << k_r;
  assign diff_x = {x_r[wpf_pkg::COORD_W-1], x_r} - {base_x_r[wpf_pkg::COORD_W-1], base_x_r};
  assign diff_y = {y_r[wpf_pkg::COORD_W-1], y_r} - {base_y_r[wpf_pkg::COORD_W-1], base_y_r};
  assign j_s    = {1'b0, j_r};
  assign shx    = prodx_r >>> k_r;
  assign shy    = prody_r >>> k_r;

  // position check terms
  assign reached   = (wpf_pkg::ISH_W'(d_res) <= wpf_pkg::ISH_W'(tol_r));
  assign last_tgt  = ((wpf_pkg::CNT_W'(tp_r) + 1'b1) >= count_r);
  assign retry_inc = (retry_r == '1) ? retry_r : retry_r + 1'b1;

  // memory write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[wpf_pkg::IDX_W-1:0];
    wr_pt   = {nx_r, ny_r, nmark_r};
    wr_seg  = d_res;
    if (cmd.op == wpf_pkg::OP_FIRST) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_pt   = {x_r, y_r, cp_r};
      wr_seg  = '0;
    end else if (cmd.op == wpf_pkg::OP_SUB_WRITE) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_mem[wr_addr]  <= wr_pt;
      seg_mem[wr_addr] <= wr_seg;
    end
    if (cmd.op == wpf_pkg::OP_TGT_READ) begin
      pt_rd_r  <= pt_mem[tp_r];
      seg_rd_r <= seg_mem[tp_r + 1'b1];
    end
  end

  // configuration registers and follower state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= wpf_pkg::TOL_RESET;
      interp_r <= wpf_pkg::INTERP_RESET;
      total_r  <= '0;
      rlimit_r <= wpf_pkg::RETRY_RESET;
      count_r  <= '0;
      raw_r    <= '0;
      tp_r     <= '0;
      cpc_r    <= '0;
      retry_r  <= '0;
      rem_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (wpf_pkg::cfg_idx_t'(cfg_idx))
          wpf_pkg::CFG_TOL:    tol_r    <= cfg_data[wpf_pkg::TOL_W-1:0];
          wpf_pkg::CFG_INTERP: interp_r <= cfg_data[wpf_pkg::TOL_W-1:0];
          wpf_pkg::CFG_TOTAL:  total_r  <= cfg_data[wpf_pkg::REM_W-1:0];
          wpf_pkg::CFG_RETRY:  rlimit_r <= cfg_data[wpf_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        wpf_pkg::OP_BEGIN: begin
          count_r <= '0;
          raw_r   <= '0;
          tp_r    <= '0;
          retry_r <= '0;
          if (rem_r == '0) rem_r <= total_r;
        end
        wpf_pkg::OP_RESET_ALL: begin
          count_r <= '0;
          raw_r   <= '0;
          tp_r    <= '0;
          cpc_r   <= '0;
          retry_r <= '0;
          rem_r   <= '0;
        end
        wpf_pkg::OP_SKIP, wpf_pkg::OP_LOAD_DIST: begin
          if (raw_r != '1) raw_r <= raw_r + 1'b1;
        end
        wpf_pkg::OP_FIRST: begin
          if (raw_r != '1) raw_r <= raw_r + 1'b1;
          count_r <= wpf_pkg::CNT_W'(1);
        end
        wpf_pkg::OP_SUB_WRITE: count_r <= count_r + 1'b1;
        wpf_pkg::OP_CHECK: begin
          if (reached && !last_tgt) begin
            if (tgt_mark && cpc_r != '1) cpc_r <= cpc_r + 1'b1;
            tp_r    <= tp_r + 1'b1;
            rem_r   <= (rem_r > wpf_pkg::REM_W'(seg_rd_r)) ?
                       rem_r - wpf_pkg::REM_W'(seg_rd_r) : '0;
            retry_r <= '0;
          end else if (!reached) begin
            retry_r <= retry_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and per-item result
  always_ff @(posedge clk) begin
    case (cmd.op)
      wpf_pkg::OP_CAPTURE: begin
        cmd_r    <= wpf_pkg::cmd_t'(in_cmd);
        x_r      <= in_x;
        y_r      <= in_y;
        cp_r     <= in_cp;
        status_r <= wpf_pkg::ST_OK;
        passed_r <= 1'b0;
        cpnum_r  <= '0;
        dev_r    <= '0;
        k_r      <= '0;
      end
      wpf_pkg::OP_FIRST: begin
        last_x_r <= x_r;
        last_y_r <= y_r;
      end
      wpf_pkg::OP_K_INC:   k_r      <= k_r + 1'b1;
      wpf_pkg::OP_FULL:    status_r <= wpf_pkg::ST_FULL;
      wpf_pkg::OP_EMPTY:   status_r <= wpf_pkg::ST_EMPTY;
      wpf_pkg::OP_SUB_INIT: begin
        base_x_r <= last_x_r;
        base_y_r <= last_y_r;
        j_r      <= wpf_pkg::J_W'(1);
      end
      wpf_pkg::OP_SUB_MUL: begin
        prodx_r <= diff_x * j_s;
        prody_r <= diff_y * j_s;
      end
      wpf_pkg::OP_SUB_ADD: begin
        if (j_r == n_sub) begin
          nx_r    <= x_r;
          ny_r    <= y_r;
          nmark_r <= cp_r;
        end else begin
          nx_r    <= base_x_r + shx[wpf_pkg::COORD_W-1:0];
          ny_r    <= base_y_r + shy[wpf_pkg::COORD_W-1:0];
          nmark_r <= 1'b0;
        end
      end
      wpf_pkg::OP_SUB_WRITE: begin
        last_x_r <= nx_r;
        last_y_r <= ny_r;
        j_r      <= j_r + 1'b1;
      end
      wpf_pkg::OP_CHECK: begin
        dev_r <= d_res;
        if (reached && last_tgt) begin
          status_r <= wpf_pkg::ST_COMPLETE;
        end else if (reached) begin
          passed_r <= tgt_mark;
          cpnum_r  <= tgt_mark ? cpc_r : '0;
          status_r <= (rlimit_r == '0) ? wpf_pkg::ST_RETRY_STOP : wpf_pkg::ST_ADVANCED;
        end else begin
          status_r <= (retry_inc >= rlimit_r) ? wpf_pkg::ST_RETRY_STOP : wpf_pkg::ST_RETRY;
        end
      end
      wpf_pkg::OP_OUT_LOAD: begin
        o_status <= status_r;
        o_passed <= passed_r;
        o_cpnum  <= cpnum_r;
        o_target <= tp_r;
        o_dev    <= dev_r;
        o_rem    <= rem_r;
        o_count  <= count_r;
      end
      default: ;
    endcase
  end

  // status to the controller
  assign stat.cmd         = cmd_r;
  assign stat.raw_lt_cpc  = (raw_r < wpf_pkg::RAW_W'(cpc_r));
  assign stat.count_zero  = (count_r == '0);
  assign stat.tp_ge_count = (wpf_pkg::CNT_W'(tp_r) >= count_r);
  assign stat.dist_done   = d_done;
  assign stat.k_more      = (k_r < wpf_pkg::K_W'(wpf_pkg::MAX_SPLIT_LOG2)) &&
                            (wpf_pkg::ISH_W'(d_res) > (wpf_pkg::ISH_W'(interp_r) << k_r));
  assign stat.fits        = ((wpf_pkg::FIT_W'(count_r) + wpf_pkg::FIT_W'(n_sub)) <=
                             wpf_pkg::FIT_W'(wpf_pkg::PATH_DEPTH));
  assign stat.last_sub    = (j_r == n_sub);

endmodule

// File: rtl/waypoint_path_follower.sv
// top level of the waypoint path follower
//
//   port     dir   transfer / write
//   in_ch    sink  cmd, x_coord, y_coord, is_checkpoint; valid & ready
//   out_ch   src   status, checkpoint fields, target, deviation, distance, count
//   cfg_*    in    cfg_we, cfg_idx, cfg_data; written on every edge with cfg_we
//
// one item at a time; begin, reset all, skipped or first points go from decode straight to the result
// a check runs one distance through the distance unit (squarer plus 25 root steps)
// a load of 2^k sub-points runs one distance for the raw span, then one distance per point
// synchronous active-low reset; path memories hold no reset and need no clearing pass
// a result waits in the output register; the next item is taken while it waits
module waypoint_path_follower (
  input  logic                                  clk,
  input  logic                                  rst_n,
  wpf_in_if.sink                                in_ch,
  wpf_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [wpf_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [wpf_pkg::CFG_DATA_W-1:0]        cfg_data
);

  wpf_pkg::dp_cmd_t  dp_cmd;
  wpf_pkg::dp_stat_t dp_stat;
  wpf_pkg::status_t  o_status;

  // controller
  wpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // datapath
  wpf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_cmd   (in_ch.cmd),
    .in_x     (in_ch.x_coord),
    .in_y     (in_ch.y_coord),
    .in_cp    (in_ch.is_checkpoint),
    .o_status (o_status),
    .o_passed (out_ch.checkpoint_passed),
    .o_cpnum  (out_ch.checkpoint_number),
    .o_target (out_ch.target_index),
    .o_dev    (out_ch.deviation),
    .o_rem    (out_ch.remaining_distance),
    .o_count  (out_ch.points_stored)
  );

  assign out_ch.status = o_status;

  // target never runs past the stored points
  a_target_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (wpf_pkg::CNT_W'(out_ch.target_index) <= out_ch.points_stored))
    else $error("target index beyond stored points");

  // a checkpoint is only reported by an advancing check
  a_cp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.checkpoint_passed) |->
      (out_ch.status == wpf_pkg::ST_ADVANCED || out_ch.status == wpf_pkg::ST_RETRY_STOP))
    else $error("checkpoint reported without advance");

  // one item in flight: no input transfer right after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

endmodule

// File: test/waypoint_path_follower_tb.sv
// self-checking testbench for the waypoint path follower: directed table then random walks
module waypoint_path_follower_tb;

  localparam longint LIMIT_CYCLES = 20000000;
  localparam logic [23:0] C_MAX = 24'h7FFFFF;
  localparam logic [23:0] C_MIN = 24'h800000;

  typedef struct packed {
    logic [2:0]  status;
    logic        passed;
    logic [9:0]  cp_num;
    logic [9:0]  target;
    logic [24:0] dev;
    logic [31:0] remaining;
    logic [10:0] stored;
  } follow_res_t;

  typedef struct {
    wpf_pkg::cmd_t cmd;
    logic [23:0]   x;
    logic [23:0]   y;
    logic          cp;
    int            typed_status;
  } path_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [wpf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [wpf_pkg::CFG_DATA_W-1:0] cfg_data;

  wpf_in_if  in_ch ();
  wpf_out_if out_ch ();

  waypoint_path_follower i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // expected follower model state
  longint      pt_x [wpf_pkg::PATH_DEPTH];
  longint      pt_y [wpf_pkg::PATH_DEPTH];
  bit          pt_mark [wpf_pkg::PATH_DEPTH];
  longint      pt_seg [wpf_pkg::PATH_DEPTH];
  int unsigned n_stored, raw_seen, tgt_ptr, cp_count, retries;
  logic [31:0] remain_len;
  logic [23:0] tol_reg, interp_reg;
  logic [31:0] total_reg;
  logic [7:0]  retry_lim;

  follow_res_t expected_results[$];
  path_cmd_t   directed_rows[$];
  int          errors = 0;
  int          burst_left;
  longint      cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("waypoint_path_follower_tb NOT OK");
      $finish;
    end
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint span(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(floor_root(longint'(dx * dx + dy * dy)));
  endfunction

  function automatic longint floor_shift(longint p, int k);
    if (p >= 0) return p >>> k;
    return -(((-p) + ((64'sd1 <<< k) - 1)) >>> k);
  endfunction

  function automatic void clear_follow();
    n_stored = 0; raw_seen = 0; tgt_ptr = 0;
    cp_count = 0; retries = 0; remain_len = '0;
  endfunction

  // store one raw point, subdividing from the last stored one
  function automatic wpf_pkg::status_t load_path_point(longint x, longint y, bit cp);
    int unsigned seen, last, n;
    longint lx, ly, d, nx, ny;
    int k;
    seen = raw_seen;
    if (raw_seen < 2047) raw_seen++;
    if (seen < cp_count) return wpf_pkg::ST_OK;
    if (n_stored == 0) begin
      pt_x[0] = x; pt_y[0] = y; pt_mark[0] = cp; pt_seg[0] = 0;
      n_stored = 1;
      return wpf_pkg::ST_OK;
    end
    last = n_stored - 1;
    lx = pt_x[last];
    ly = pt_y[last];
    d = span(x, y, lx, ly);
    k = 0;
    while (k < wpf_pkg::MAX_SPLIT_LOG2 && d > (longint'(interp_reg) << k)) k++;
    n = 1 << k;
    if (n_stored + n > wpf_pkg::PATH_DEPTH) return wpf_pkg::ST_FULL;
    for (int j = 1; j <= n; j++) begin
      if (j == n) begin
        nx = x; ny = y;
      end else begin
        nx = lx + floor_shift((x - lx) * j, k);
        ny = ly + floor_shift((y - ly) * j, k);
      end
      pt_seg[n_stored] = span(nx, ny, pt_x[n_stored-1], pt_y[n_stored-1]);
      pt_x[n_stored] = nx;
      pt_y[n_stored] = ny;
      pt_mark[n_stored] = (j == n) ? cp : 1'b0;
      n_stored++;
    end
    return wpf_pkg::ST_OK;
  endfunction

  // expected result of one accepted command
  function automatic follow_res_t follow_step(path_cmd_t c);
    follow_res_t r;
    wpf_pkg::status_t st;
    longint x, y, dev, len;
    int unsigned t;
    r = '0;
    st = wpf_pkg::ST_OK;
    dev = 0;
    x = longint'($signed(c.x));
    y = longint'($signed(c.y));
    case (c.cmd)
      wpf_pkg::CMD_BEGIN: begin
        n_stored = 0; raw_seen = 0; tgt_ptr = 0; retries = 0;
        if (remain_len == 0) remain_len = total_reg;
      end
      wpf_pkg::CMD_LOAD: st = load_path_point(x, y, c.cp);
      wpf_pkg::CMD_CHECK: begin
        if (n_stored == 0 || tgt_ptr >= n_stored) begin
          st = wpf_pkg::ST_EMPTY;
        end else begin
          t = tgt_ptr;
          dev = span(x, y, pt_x[t], pt_y[t]);
          if (t + 1 >= n_stored && dev <= tol_reg) begin
            st = wpf_pkg::ST_COMPLETE;
          end else begin
            if (dev <= tol_reg) begin
              if (pt_mark[t]) begin
                r.passed = 1'b1;
                r.cp_num = cp_count[9:0];
                if (cp_count < 1023) cp_count++;
              end
              tgt_ptr = t + 1;
              len = pt_seg[t+1];
              remain_len = (longint'(remain_len) > len) ? 32'(longint'(remain_len) - len) : '0;
              retries = 0;
              st = wpf_pkg::ST_ADVANCED;
            end else begin
              if (retries < 255) retries++;
              st = wpf_pkg::ST_RETRY;
            end
            if (retries >= retry_lim) st = wpf_pkg::ST_RETRY_STOP;
          end
        end
      end
      default: clear_follow();
    endcase
    r.status = st;
    r.target = tgt_ptr[9:0];
    r.dev = dev[24:0];
    r.remaining = remain_len;
    r.stored = n_stored[10:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // send one command, bursts of transfers with gaps between them
  task automatic send(path_cmd_t c);
    follow_res_t r;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = c.cmd;
    in_ch.x_coord = c.x;
    in_ch.y_coord = c.y;
    in_ch.is_checkpoint = c.cp;
    do @(posedge clk); while (!in_ch.ready);
    r = follow_step(c);
    if (c.typed_status >= 0) r.status = 3'(c.typed_status);
    expected_results.insert(expected_results.size(), r);
    burst_left--;
    @(negedge clk);
  endtask

  // wait until every expected result has come back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(wpf_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      wpf_pkg::CFG_TOL:    tol_reg = val[23:0];
      wpf_pkg::CFG_INTERP: interp_reg = val[23:0];
      wpf_pkg::CFG_TOTAL:  total_reg = val;
      default:             retry_lim = val[7:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(logic [31:0] tol, logic [31:0] interp, logic [31:0] total,
                          logic [31:0] rlim);
    write_reg(wpf_pkg::CFG_TOL, tol);
    write_reg(wpf_pkg::CFG_INTERP, interp);
    write_reg(wpf_pkg::CFG_TOTAL, total);
    write_reg(wpf_pkg::CFG_RETRY, rlim);
  endtask

  function automatic void row(wpf_pkg::cmd_t cmd, logic [23:0] x, logic [23:0] y, logic cp,
                              int st);
    path_cmd_t c;
    c.cmd = cmd; c.x = x; c.y = y; c.cp = cp; c.typed_status = st;
    directed_rows.insert(directed_rows.size(), c);
  endfunction

  function automatic longint jitter(int unsigned m);
    return longint'($urandom_range(0, 2 * m)) - longint'(m);
  endfunction

  // random command, mostly walks along a path and checks near the target
  function automatic path_cmd_t random_cmd(int unsigned step);
    path_cmd_t c;
    int unsigned r, near;
    longint bx, by;
    r = $urandom_range(0, 99);
    c.typed_status = -1;
    c.x = 24'($urandom());
    c.y = 24'($urandom());
    c.cp = $urandom_range(0, 2) == 0;
    if (n_stored > 900 || r < 4) begin
      c.cmd = wpf_pkg::CMD_BEGIN;
    end else if (r < 7) begin
      c.cmd = wpf_pkg::CMD_RESET;
    end else if (r < 42) begin
      c.cmd = wpf_pkg::CMD_LOAD;
      if (n_stored != 0) begin
        bx = pt_x[n_stored-1];
        by = pt_y[n_stored-1];
        if ($urandom_range(0, 9) != 0) begin
          bx += jitter(step);
          by += jitter(step);
        end
        c.x = 24'(bx);
        c.y = 24'(by);
      end
    end else if (r < 94) begin
      c.cmd = wpf_pkg::CMD_CHECK;
      if (tgt_ptr < n_stored) begin
        near = (tol_reg > 2000) ? 1000 : tol_reg / 2;
        bx = pt_x[tgt_ptr];
        by = pt_y[tgt_ptr];
        case ($urandom_range(0, 2))
          0: ;
          1: begin bx += jitter(near); by += jitter(near); end
          default: begin bx += jitter(60000); by += jitter(60000); end
        endcase
        c.x = 24'(bx);
        c.y = 24'(by);
      end
    end else begin
      c.cmd = wpf_pkg::cmd_t'($urandom_range(0, 3));
    end
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    follow_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_ch.status, 0);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
        if (out_ch.checkpoint_passed !== e.passed)
          report("checkpoint_passed", out_ch.checkpoint_passed, e.passed);
        if (out_ch.checkpoint_number !== e.cp_num)
          report("checkpoint_number", out_ch.checkpoint_number, e.cp_num);
        if (out_ch.target_index !== e.target)
          report("target_index", out_ch.target_index, e.target);
        if (out_ch.deviation !== e.dev) report("deviation", out_ch.deviation, e.dev);
        if (out_ch.remaining_distance !== e.remaining)
          report("remaining_distance", out_ch.remaining_distance, e.remaining);
        if (out_ch.points_stored !== e.stored)
          report("points_stored", out_ch.points_stored, e.stored);
      end
    end
  end

  // receiver stalls in changing patterns
  initial begin
    int unsigned mode, left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(5, 200);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 1);
        default: out_ch.ready = $urandom_range(0, 7) == 0;
      endcase
    end
  end

  // stimulus
  initial begin
    int unsigned steps [4];
    burst_left = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = wpf_pkg::CMD_BEGIN;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.is_checkpoint = 1'b0;
    tol_reg = 24'd256; interp_reg = 24'd256; total_reg = '0; retry_lim = 8'd40;
    clear_follow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty, extremes, full, checkpoint, skip, complete, reset all
    set_regs(256, 256, 1000, 40);
    row(wpf_pkg::CMD_CHECK, 24'd0, 24'd0, 1'b0, int'(wpf_pkg::ST_EMPTY));
    row(wpf_pkg::CMD_BEGIN, 24'd0, 24'd0, 1'b0, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  24'd0, 24'd0, 1'b1, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  C_MAX, C_MIN, 1'b0, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  C_MIN, C_MAX, 1'b1, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  C_MAX, C_MIN, 1'b0, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  C_MIN, C_MAX, 1'b1, int'(wpf_pkg::ST_FULL));
    row(wpf_pkg::CMD_CHECK, 24'd0, 24'd0, 1'b0, int'(wpf_pkg::ST_ADVANCED));
    row(wpf_pkg::CMD_CHECK, C_MIN, C_MIN, 1'b0, int'(wpf_pkg::ST_RETRY));
    row(wpf_pkg::CMD_CHECK, C_MAX, C_MAX, 1'b1, -1);
    row(wpf_pkg::CMD_BEGIN, 24'd0, 24'd0, 1'b0, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  24'd5, 24'd5, 1'b1, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  24'hFFFFFF, 24'hFFFFFF, 1'b0, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_LOAD,  24'hFFFFFF, 24'h000100, 1'b1, -1);
    row(wpf_pkg::CMD_CHECK, 24'hFFFFFF, 24'hFFFFFF, 1'b0, -1);
    row(wpf_pkg::CMD_CHECK, 24'hFFFFFF, 24'h000100, 1'b0, int'(wpf_pkg::ST_ADVANCED));
    row(wpf_pkg::CMD_CHECK, 24'hFFFFFF, 24'h000100, 1'b0, int'(wpf_pkg::ST_COMPLETE));
    row(wpf_pkg::CMD_CHECK, 24'hFFFFFF, 24'h000100, 1'b0, int'(wpf_pkg::ST_COMPLETE));
    row(wpf_pkg::CMD_RESET, 24'd0, 24'd0, 1'b0, int'(wpf_pkg::ST_OK));
    row(wpf_pkg::CMD_CHECK, 24'd0, 24'd0, 1'b0, int'(wpf_pkg::ST_EMPTY));
    foreach (directed_rows[i]) send(directed_rows[i]);
    drain();

    // random phases across register settings, extremes included
    steps = '{100000, 16000, 2000, 60};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(1024, 24'hFFFFFF, 32'hFFFFFFFF, 1);
        1: set_regs(24'hFFFFFF, 4096, 12345678, 255);
        2: set_regs(1, 200, 0, 40);
        default: set_regs(300, 1, 0, 3);
      endcase
      for (int i = 0; i < 100; i++) send(random_cmd(steps[ph]));
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("waypoint_path_follower_tb OK");
    end else begin
      $display("waypoint_path_follower_tb NOT OK");
    end
    $finish;
  end

endmodule
